// ===== hw/rtl/srtc_pkg.sv =====
`default_nettype none

package srtc_pkg;

  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_NL  = 8'd10;
  localparam logic [7:0] CH_BS  = 8'o10;
  localparam logic [7:0] CH_ESC = 8'o33;
  localparam logic [7:0] CH_SP  = 8'd32;
  localparam logic [7:0] STOP_MASK = 8'o7;

  typedef enum logic [0:0] {
    S_IDLE,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic accept_space;
    logic accept_char;
    logic load_pass;
    logic emit_flush;
    logic emit_char;
  } cmd_t;

  typedef struct packed {
    logic passthrough;
    logic in_space;
    logic pend_zero;
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/srtc_ctrl.sv =====
`default_nettype none

module srtc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire srtc_pkg::status_t sts,
  output srtc_pkg::cmd_t        cmd
);
  import srtc_pkg::*;

  state_t state;
  state_t state_next;
  logic   slot_free;
  logic   out_load;

  assign slot_free = !out_valid || out_ready;
  assign out_load  = cmd.load_pass || cmd.emit_flush || cmd.emit_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = slot_free;
        if (in_valid && slot_free) begin
          if (sts.passthrough) begin
            cmd.load_pass = 1'b1;
          end else if (sts.in_space) begin
            cmd.accept_space = 1'b1;
          end else begin
            cmd.accept_char = 1'b1;
            state_next      = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          if (sts.pend_zero) begin
            cmd.emit_char = 1'b1;
            state_next    = S_IDLE;
          end else begin
            cmd.emit_flush = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/srtc_datapath.sv =====
`default_nettype none

module srtc_datapath #(
  parameter int COL_MAX = 255
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_write,
  input  wire logic          cfg_data,
  input  wire logic [7:0]    char_in,
  input  wire srtc_pkg::cmd_t cmd,
  output srtc_pkg::status_t  sts,
  output logic [7:0]         char_out,
  output logic               last
);
  import srtc_pkg::*;

  localparam logic [7:0] ColMax = 8'(COL_MAX);

  logic       passthrough;
  logic [7:0] column;
  logic [7:0] pending;
  logic [7:0] ch;

  logic [7:0] col_space;
  logic [7:0] run_start;
  logic [7:0] run_stop;
  logic       tab_ok;
  logic [7:0] pend_tab;

  assign col_space = (column < ColMax) ? column + 8'd1 : column;
  assign run_start = column - pending;
  assign run_stop  = run_start | STOP_MASK;
  assign tab_ok    = (pending > 8'd2) && (column > run_stop);
  assign pend_tab  = column - run_stop - 8'd1;

  assign sts.passthrough = passthrough;
  assign sts.in_space    = (char_in == CH_SP);
  assign sts.pend_zero   = (pending == 8'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      passthrough <= 1'b0;
      column      <= 8'd0;
      pending     <= 8'd0;
    end else begin
      if (cfg_write) begin
        passthrough <= cfg_data;
      end
      if (cmd.accept_space) begin
        column <= col_space;
        if (pending < col_space) begin
          pending <= pending + 8'd1;
        end
      end else if (cmd.accept_char) begin
        if (char_in == CH_NL) begin
          column  <= 8'd0;
          pending <= 8'd0;
        end else if (char_in == CH_BS || char_in == CH_ESC) begin
          if (column != 8'd0) begin
            column <= column - 8'd1;
          end
          if (pending != 8'd0) begin
            pending <= pending - 8'd1;
          end
        end
      end else if (cmd.emit_flush) begin
        pending <= tab_ok ? pend_tab : pending - 8'd1;
      end else if (cmd.emit_char) begin
        if (ch >= CH_SP && column < ColMax) begin
          column <= column + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_char) begin
      ch <= char_in;
    end
    if (cmd.load_pass) begin
      char_out <= char_in;
      last     <= 1'b1;
    end else if (cmd.emit_flush) begin
      char_out <= tab_ok ? CH_TAB : CH_SP;
      last     <= 1'b0;
    end else if (cmd.emit_char) begin
      char_out <= ch;
      last     <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/space_run_tab_compressor.sv =====
`default_nettype none

// Compresses runs of spaces in a printer character stream into tabs on an
// 8-column grid. Outside passthrough mode a space produces no beat; any other
// character is stored, the tabs and spaces pending ahead of it are flushed,
// and it is then emitted as the final beat. The flush emits one beat per cycle
// while the output slot is free, from a single column/pending update step. In
// passthrough mode each character goes to the output register as a final beat.
// A new character is accepted no earlier than the cycle in which the previous
// beat is taken from the output register. The column saturates at COL_MAX, and
// the passthrough bit must only be written while the block is idle.
module space_run_tab_compressor #(
  parameter int COL_MAX = 255
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic       cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] char_in,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      char_out,
  output logic            last
);
  import srtc_pkg::*;

  cmd_t    cmd;
  status_t sts;

  srtc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  srtc_datapath #(
    .COL_MAX (COL_MAX)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .char_in   (char_in),
    .cmd       (cmd),
    .sts       (sts),
    .char_out  (char_out),
    .last      (last)
  );

`ifndef SYNTHESIS
  a_busy_after_char: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !sts.passthrough && !sts.in_space) |=> !in_ready)
    else $error("input taken while a character is being flushed");

  a_char_is_last: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_char |=> (out_valid && last))
    else $error("emitted character not marked as final beat");

  a_flush_beat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (char_out == CH_TAB || char_out == CH_SP))
    else $error("non-final beat is neither tab nor space");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srtc_pkg::*;

  localparam int COL_MAX = 255;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] chr;
    logic       fin;
  } beat_t;

  typedef enum logic {
    ROW_CHAR,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] chr;
    int         rep;
    logic       typed;
    logic [7:0] want;
  } row_t;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic       cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] char_in;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] char_out;
  logic       last;

  beat_t beats_due[$];
  beat_t flush_beats[$];
  beat_t got_head;
  row_t  plan [0:22];

  logic bypass;
  int   col;
  int   pend;
  int   peak_col;
  int   longest_flush;
  int   sent;
  int   beats_seen;
  int   tabs_seen;
  int   errors;
  int   idle_run;
  bit   calm;
  bit   quiet_tail;
  bit   hold_out;

  space_run_tab_compressor #(
    .COL_MAX(COL_MAX)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .char_in  (char_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .char_out (char_out),
    .last     (last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void compress_char(input logic [7:0] c);
    int lo;
    int stop;
    flush_beats.delete();
    if (bypass) begin
      flush_beats.push_back('{chr: c, fin: 1'b1});
      return;
    end
    if (col > COL_MAX) col = COL_MAX;
    if (pend > col) pend = col;
    if (c == CH_SP) begin
      if (col < COL_MAX) col++;
      if (pend < col) pend++;
      if (col > peak_col) peak_col = col;
      return;
    end
    if (c == CH_NL) begin
      col = 0;
      pend = 0;
    end else if (c == CH_BS || c == CH_ESC) begin
      if (col > 0) col--;
      if (pend > 0) pend--;
    end
    while (pend > 0) begin
      lo = col - pend;
      stop = lo | int'(STOP_MASK);
      if (pend > 2 && col > stop) begin
        pend = col - stop - 1;
        flush_beats.push_back('{chr: CH_TAB, fin: 1'b0});
      end else begin
        pend--;
        flush_beats.push_back('{chr: CH_SP, fin: 1'b0});
      end
    end
    if (c >= CH_SP && col < COL_MAX) col++;
    if (col > peak_col) peak_col = col;
    flush_beats.push_back('{chr: c, fin: 1'b1});
  endfunction

  task automatic offer_char(input logic [7:0] c, input logic typed = 1'b0,
                            input logic [7:0] want = 8'h00);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    compress_char(c);
    if (flush_beats.size() > longest_flush) longest_flush = flush_beats.size();
    if (typed) begin
      beats_due.push_back('{chr: want, fin: 1'b1});
    end else begin
      foreach (flush_beats[i]) beats_due.push_back(flush_beats[i]);
    end
  endtask

  task automatic set_mode(input logic v);
    in_valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    bypass = v;
  endtask

  task automatic run_line(input int cap);
    int len;
    int n;
    int k;
    int run;
    len = $urandom_range(1, cap);
    calm = quiet_tail || ($urandom_range(0, 4) == 0);
    if (bypass || $urandom_range(0, 9) == 0) begin
      repeat (len) offer_char(8'($urandom_range(0, 255)));
    end else begin
      n = 0;
      while (n < len) begin
        k = $urandom_range(0, 19);
        if (k < 11) begin
          offer_char(8'($urandom_range(8'h21, 8'h7e)));
        end else if (k < 12) begin
          offer_char(8'($urandom_range(8'h80, 8'hff)));
        end else if (k < 16) begin
          run = $urandom_range(1, 12);
          repeat (run) offer_char(CH_SP);
          n += run - 1;
        end else if (k < 17) begin
          offer_char(CH_BS);
        end else if (k < 18) begin
          offer_char(CH_ESC);
        end else begin
          offer_char(8'($urandom_range(0, 31)));
        end
        n++;
      end
      if ($urandom_range(0, 4) != 0) offer_char(CH_NL);
    end
  endtask

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        hold_out = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      beats_seen++;
      if (char_out == CH_TAB) tabs_seen++;
      if (beats_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, got char_out %02h last %0b",
                 $time, char_out, last);
      end else begin
        got_head = beats_due.pop_front();
        if (char_out !== got_head.chr) begin
          errors++;
          $display("%0t: char_out expected %02h, got %02h", $time, got_head.chr, char_out);
        end
        if (last !== got_head.fin) begin
          errors++;
          $display("%0t: last expected %0b, got %0b", $time, got_head.fin, last);
        end
      end
    end
  end

  initial begin
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_run = 0;
      else idle_run++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data <= 1'b0;
    in_valid <= 1'b0;
    char_in <= 8'h00;
    bypass = 1'b0;
    col = 0;
    pend = 0;
    peak_col = 0;
    longest_flush = 0;
    sent = 0;
    beats_seen = 0;
    tabs_seen = 0;
    errors = 0;
    calm = 1'b0;
    quiet_tail = 1'b0;
    hold_out = 1'b0;

    plan = '{
      '{ROW_CHAR, 8'h41,   1, 1'b1, 8'h41},
      '{ROW_CHAR, CH_NL,   1, 1'b1, CH_NL},
      '{ROW_CHAR, 8'h00,   1, 1'b1, 8'h00},
      '{ROW_CHAR, 8'hff,   1, 1'b1, 8'hff},
      '{ROW_CHAR, CH_BS,   1, 1'b1, CH_BS},
      '{ROW_CHAR, CH_ESC,  1, 1'b1, CH_ESC},
      '{ROW_CHAR, CH_SP,   9, 1'b0, 8'h00},
      '{ROW_CHAR, 8'h78,   1, 1'b0, 8'h00},
      '{ROW_CHAR, CH_SP,   2, 1'b0, 8'h00},
      '{ROW_CHAR, CH_BS,   1, 1'b0, 8'h00},
      '{ROW_CHAR, CH_SP,   1, 1'b0, 8'h00},
      '{ROW_CHAR, 8'h07,   1, 1'b0, 8'h00},
      '{ROW_CHAR, CH_SP,   4, 1'b0, 8'h00},
      '{ROW_CHAR, CH_ESC,  1, 1'b0, 8'h00},
      '{ROW_CHAR, CH_SP,   1, 1'b0, 8'h00},
      '{ROW_CHAR, CH_NL,   1, 1'b1, CH_NL},
      '{ROW_CFG,  8'h01,   1, 1'b0, 8'h00},
      '{ROW_CHAR, CH_SP,   1, 1'b1, CH_SP},
      '{ROW_CHAR, CH_NL,   1, 1'b1, CH_NL},
      '{ROW_CHAR, 8'h80,   1, 1'b1, 8'h80},
      '{ROW_CFG,  8'h00,   1, 1'b0, 8'h00},
      '{ROW_CHAR, 8'h79,   1, 1'b0, 8'h00},
      '{ROW_CHAR, 8'h7f,   1, 1'b0, 8'h00}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        set_mode(plan[i].chr[0]);
      end else begin
        repeat (plan[i].rep) offer_char(plan[i].chr, plan[i].typed, plan[i].want);
      end
    end

    while (sent < 80) run_line(30);

    set_mode(1'b1);
    hold_out = 1'b1;
    calm = 1'b1;
    repeat (20) offer_char(8'($urandom_range(0, 255)));
    while (sent < 115) run_line(10);

    set_mode(1'b0);
    hold_out = 1'b1;
    calm = 1'b1;
    repeat (12) offer_char(CH_SP);
    offer_char(8'h2e);
    offer_char(CH_NL);
    repeat (262) offer_char(CH_SP);
    offer_char(8'($urandom_range(8'h21, 8'h7e)));
    repeat (5) offer_char(CH_SP);
    offer_char(CH_BS);
    offer_char(CH_SP);
    offer_char(CH_ESC);
    offer_char(CH_NL);

    while (sent < 405) run_line(30);
    quiet_tail = 1'b1;
    while (sent < 430) run_line(30);

    in_valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (beats_due.size() != 0) begin
      errors++;
      $display("%0t: %0d expected beats never arrived", $time, beats_due.size());
    end

    $display("Sent %0d characters and checked %0d beats (%0d tabs); longest flush %0d beats.",
             sent, beats_seen, tabs_seen, longest_flush);
    $display("Both modes ran, the column reached %0d, and the output held off %0d cycles.",
             peak_col, HOLD_CYCLES);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/srtc_pkg.sv
hw/rtl/srtc_ctrl.sv
hw/rtl/srtc_datapath.sv
hw/rtl/space_run_tab_compressor.sv
tb/tb.sv
